FILE: rtl/tts_pkg.sv
// ----------------------------------------------------------------------------
// Texture sampler package
// Shared constants, types and address helpers of the trilinear sampler.
// ----------------------------------------------------------------------------
package tts_pkg;

	localparam int MaxLog2 = 8;
	localparam int StoreDepth = ((1 << (2 * (MaxLog2 + 1))) - 1) / 3;
	localparam int AddrW = $clog2(StoreDepth);
	localparam int LvlW = 4;
	localparam int CoordOne = 65536;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	localparam logic [1:0] REG_WIDTH = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_LEVELS = 2'd2;
	localparam logic [1:0] REG_READY = 2'd3;

	// One request as the front end hands it to the filter pipeline.
	typedef struct packed {
		logic             is_sample;
		logic             fallback;
		logic [LvlW-1:0]  lvl_a;
		logic [LvlW-1:0]  lvl_b;
		logic [7:0]       frac_l;
		logic [16:0]      u;
		logic [16:0]      v;
		logic [3:0]       wlog;
		logic [3:0]       hlog;
		logic [AddrW-1:0] waddr;
		logic [23:0]      wdata;
	} req_t;

	// Start of a level inside the packed mip chain.
	function automatic logic [AddrW-1:0] level_base(input logic [LvlW-1:0] lv);
		logic [AddrW-1:0] off;
		off = '0;
		for (int k = 0; k <= MaxLog2; k++) begin
			if (k < int'(lv))
				off = off + AddrW'(1 << (2 * (MaxLog2 - k)));
		end
		return off;
	endfunction

	function automatic logic [3:0] dim_log2(input logic [3:0] lg, input logic [LvlW-1:0] lv);
		return (lg > lv) ? 4'(lg - lv) : 4'd0;
	endfunction

endpackage

FILE: rtl/tts_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port, registered read data with a read
// enable that holds the last read word.
// ----------------------------------------------------------------------------
module tts_ram #(
	parameter int Width = 24,
	parameter int Depth = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (re)
			rdata <= mem_q[raddr];
	end
endmodule

FILE: rtl/tts_front.sv
// ----------------------------------------------------------------------------
// Sampler front end
// Holds the registers, classifies requests, clamps coordinates and level.
// ----------------------------------------------------------------------------
module tts_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_index,
	input  logic [3:0]           cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [90:0]          in_data,
	output logic                 q_push,
	output tts_pkg::req_t        q_req,
	input  logic                 q_full
);
	logic [3:0] wlog_q, hlog_q, lvls_q;
	logic       rdy_q;
	logic [3:0] ew, eh, en, last;
	logic       op;
	logic [3:0] lv, l1, l2;
	logic [7:0] tx, ty, fl;
	logic [16:0] u, v;
	logic [11:0] lod;
	logic [3:0] wl, hl;
	logic [7:0] mx, my;
	tts_pkg::req_t r;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wlog_q <= '0; hlog_q <= '0; lvls_q <= 4'd1; rdy_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				tts_pkg::REG_WIDTH:  wlog_q <= cfg_data;
				tts_pkg::REG_HEIGHT: hlog_q <= cfg_data;
				tts_pkg::REG_LEVELS: lvls_q <= cfg_data;
				tts_pkg::REG_READY:  rdy_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign in_ready = !q_full;
	assign q_push = in_valid && !q_full;

	always_comb begin
		ew = (wlog_q > 4'(tts_pkg::MaxLog2)) ? 4'(tts_pkg::MaxLog2) : wlog_q;
		eh = (hlog_q > 4'(tts_pkg::MaxLog2)) ? 4'(tts_pkg::MaxLog2) : hlog_q;
		en = (lvls_q < 4'd1) ? 4'd1 :
		     (lvls_q > 4'(tts_pkg::MaxLog2 + 1)) ? 4'(tts_pkg::MaxLog2 + 1) : lvls_q;
		last = en - 4'd1;
		op  = in_data[0];
		lv  = in_data[4:1];
		tx  = in_data[12:5];
		ty  = in_data[20:13];
		u   = (in_data[61:45] > 17'(tts_pkg::CoordOne)) ? 17'(tts_pkg::CoordOne)
		                                                : in_data[61:45];
		v   = (in_data[78:62] > 17'(tts_pkg::CoordOne)) ? 17'(tts_pkg::CoordOne)
		                                                : in_data[78:62];
		lod = in_data[90:79];
		l1 = lod[11:8];
		fl = lod[7:0];
		if (l1 >= last) begin
			l1 = last; fl = '0;
		end
		l2 = (l1 + 4'd1 > last) ? last : l1 + 4'd1;
		wl = tts_pkg::dim_log2(ew, lv);
		hl = tts_pkg::dim_log2(eh, lv);
		mx = tx & 8'((9'd1 << wl) - 9'd1);
		my = ty & 8'((9'd1 << hl) - 9'd1);
		r.is_sample = op;
		r.lvl_a = l1;
		r.lvl_b = l2;
		r.frac_l = fl;
		r.u = u;
		r.v = v;
		r.wlog = ew;
		r.hlog = eh;
		// A sample falls back to magenta without a texture; a write at or
		// beyond the level count becomes a no-op.
		r.fallback = (op == tts_pkg::OP_SAMPLE) ? !rdy_q : (lv >= en);
		r.waddr = tts_pkg::level_base(lv) +
		          tts_pkg::AddrW'({my, 8'd0} >> lv) + tts_pkg::AddrW'(mx);
		r.wdata = {in_data[28:21], in_data[36:29], in_data[44:37]};
		q_req = r;
	end
endmodule

FILE: rtl/tts_queue.sv
// ----------------------------------------------------------------------------
// Request queue
// Two-entry FIFO between the front end and the filter pipeline.
// ----------------------------------------------------------------------------
module tts_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  tts_pkg::req_t din,
	output logic          full,
	input  logic          pop,
	output logic          not_empty,
	output tts_pkg::req_t dout
);
	tts_pkg::req_t mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	assign full = cnt_q == 2'd2;
	assign not_empty = cnt_q != 2'd0;
	assign dout = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wp_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
		end else begin
			if (push) wp_q <= !wp_q;
			if (pop) rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end
endmodule

FILE: rtl/tts_back.sv
// ----------------------------------------------------------------------------
// Filter back end
// Fetches eight texels over two passes and blends them trilinearly.
// ----------------------------------------------------------------------------
module tts_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_valid,
	input  tts_pkg::req_t q_req,
	output logic          q_pop,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [24:0]   out_data
);
	// Sequencer: pass 0 fetches level a, pass 1 level b (one texel per bank
	// per pass).
	logic          pass_q;
	logic          busy_s1;
	logic          v_s1, v_s2, v_s3, v_s4;
	logic          p_s1, p_s2;
	logic          hold;
	logic [tts_pkg::AddrW-1:0] ra [4];
	logic [23:0]   rd [4];
	logic          we;
	logic [7:0]    fu_s1, fv_s1, fv_s2, fl_s1, fl_s2, fl_s3;
	logic [16:0]   top [3], bot [3];
	logic          fb_s1, fb_s2, fb_s3, fb_s4;
	logic [23:0]   res_s4;
	logic [3:0]    lv;
	logic [3:0]    wl, hl;
	logic [24:0]   su, sv;
	logic [7:0]    x0, y0, x1, y1, wm, hm;
	logic [tts_pkg::AddrW-1:0] base;
	logic [7:0]    fu, fv;

	assign hold = out_valid && !out_ready;
	// A write or a fallback sample leaves the queue in a single pass, a filtered sample after its two passes.
	assign we = q_valid && !hold && !q_req.is_sample && !q_req.fallback;
	assign q_pop = q_valid && !hold &&
	               (!q_req.is_sample || q_req.fallback || pass_q);

	always_comb begin
		lv = pass_q ? q_req.lvl_b : q_req.lvl_a;
		wl = tts_pkg::dim_log2(q_req.wlog, lv);
		hl = tts_pkg::dim_log2(q_req.hlog, lv);
		wm = 8'((9'd1 << wl) - 9'd1);
		hm = 8'((9'd1 << hl) - 9'd1);
		su = 25'(q_req.u) * 25'(wm);
		sv = 25'(q_req.v) * 25'(hm);
		x0 = su[23:16] & wm;
		y0 = sv[23:16] & hm;
		fu = su[15:8];
		fv = sv[15:8];
		x1 = (x0 + 8'd1) & wm;
		y1 = (y0 + 8'd1) & hm;
		base = tts_pkg::level_base(lv);
		ra[0] = base + tts_pkg::AddrW'({y0, 8'd0} >> lv) + tts_pkg::AddrW'(x0);
		ra[1] = base + tts_pkg::AddrW'({y0, 8'd0} >> lv) + tts_pkg::AddrW'(x1);
		ra[2] = base + tts_pkg::AddrW'({y1, 8'd0} >> lv) + tts_pkg::AddrW'(x0);
		ra[3] = base + tts_pkg::AddrW'({y1, 8'd0} >> lv) + tts_pkg::AddrW'(x1);
	end

	// The read data is stage 1, so it holds along with the rest of the pipe.
	for (genvar b = 0; b < 4; b++) begin : g_bank
		tts_ram #(.Width(24), .Depth(tts_pkg::StoreDepth)) u_ram (
			.clk  (clk),
			.we   (we),
			.waddr(q_req.waddr),
			.wdata(q_req.wdata),
			.re   (!hold),
			.raddr(ra[b]),
			.rdata(rd[b])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pass_q <= 1'b0;
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0;
			busy_s1 <= 1'b0;
		end else if (!hold) begin
			pass_q <= q_valid && q_req.is_sample && !q_req.fallback && !pass_q;
			v_s1 <= q_valid && q_req.is_sample && (q_req.fallback || pass_q);
			busy_s1 <= q_valid && q_req.is_sample && !q_req.fallback;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	assign out_valid = v_s4;

	// Datapath: stage 1 holds RAM output, stage 2 horizontal blend,
	// stage 3 vertical blend, stage 4 level blend and rounding.
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			top[c] = 17'(rd[0][23-8*c -: 8]) * 17'(9'd256 - 9'(fu_s1)) +
			         17'(rd[1][23-8*c -: 8]) * 17'(fu_s1);
			bot[c] = 17'(rd[2][23-8*c -: 8]) * 17'(9'd256 - 9'(fu_s1)) +
			         17'(rd[3][23-8*c -: 8]) * 17'(fu_s1);
		end
	end

	// Registers that carry the blend; the first level's result waits in va_q.
	logic [16:0] h_top_s2 [3], h_bot_s2 [3];
	logic [24:0] vert [3];
	logic [24:0] vq_s3 [3];
	logic [24:0] va_q [3];
	logic        lvlb_s2;

	always_ff @(posedge clk) begin
		if (!hold) begin
			fu_s1 <= fu; fv_s1 <= fv; fl_s1 <= q_req.frac_l;
			fb_s1 <= q_req.fallback; p_s1 <= pass_q;
			for (int c = 0; c < 3; c++) begin
				h_top_s2[c] <= top[c];
				h_bot_s2[c] <= bot[c];
			end
			fv_s2 <= fv_s1; fl_s2 <= fl_s1; fb_s2 <= fb_s1; p_s2 <= p_s1;
			lvlb_s2 <= busy_s1;
			for (int c = 0; c < 3; c++) begin
				vq_s3[c] <= vert[c];
				if (lvlb_s2 && !p_s2) va_q[c] <= vert[c];
			end
			fl_s3 <= fl_s2; fb_s3 <= fb_s2;
			for (int c = 0; c < 3; c++)
				res_s4[23-8*c -: 8] <= 8'(((64'(va_q[c]) * 64'(9'd256 - 9'(fl_s3)) +
				                     64'(vq_s3[c]) * 64'(fl_s3)) + 64'(1 << 23)) >> 24);
			fb_s4 <= fb_s3;
		end
	end

	always_comb begin
		for (int c = 0; c < 3; c++)
			vert[c] = 25'(h_top_s2[c]) * 25'(9'd256 - 9'(fv_s2)) +
			          25'(h_bot_s2[c]) * 25'(fv_s2);
	end

	assign out_data = fb_s4 ? {1'b1, 8'd255, 8'd0, 8'd255} :
	                  {1'b0, res_s4[7:0], res_s4[15:8], res_s4[23:16]};
endmodule

FILE: rtl/trilinear_texture_sampler.sv
// ----------------------------------------------------------------------------
// Trilinear texture sampler
// A filtered sample result goes through two fetch passes, then the RAM read,
// horizontal, vertical and level blend stages; a magenta fallback result needs
// one pass only. Throughput: one write or fallback sample per cycle while the
// result is not stalled; a filtered sample takes two fetch passes of four texels over the four-bank texel store.
// A stalled result holds the whole back end; the two-entry queue then fills.
// Reset clears the configuration registers and control; the texel store is
// undefined until written and needs no clearing pass.
// ----------------------------------------------------------------------------
module trilinear_texture_sampler (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [3:0]  cfg_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// op, level, texel_x, texel_y, red_in, green_in, blue_in, coord_u,
	// coord_v, detail_level (lowest bit first), zero padded
	input  logic [95:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// red_out, green_out, blue_out, used_fallback, zero padded
	output logic [31:0] m_axis_tdata
);
	tts_pkg::req_t fq, bq;
	logic push, full, pop, ne;
	logic [24:0] od;

	// Front end: register file and request classification.
	tts_front u_front (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.in_data(s_axis_tdata[90:0]),
		.q_push(push), .q_req(fq), .q_full(full)
	);

	// The queue lets the front keep taking requests while the back stalls.
	tts_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.push(push), .din(fq), .full(full),
		.pop(pop), .not_empty(ne), .dout(bq)
	);

	// Back end: texel store banks and the blend pipeline.
	tts_back u_back (
		.clk(clk), .arst_n(arst_n),
		.q_valid(ne), .q_req(bq), .q_pop(pop),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.out_data(od)
	);

	assign m_axis_tdata = {7'd0, od};
endmodule
